// File: sv/swiqr_pkg.sv
// Shared types and fixed field widths for the sliding-window IQR outlier block.
package swiqr_pkg;

  // Fixed field widths of the item ports
  localparam int CHAN_W   = 2;
  localparam int SAMPLE_W = 12;
  localparam int FENCE_W  = 14;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD,
    ST_SCAN,
    ST_MERGE,
    ST_DONE
  } swiqr_state_t;

  // Control of the sorted-copy memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
  } srt_ctl_t;

  // One result beat
  typedef struct packed {
    logic                      outlier;
    logic [FENCE_W-1:0]        upper;
    logic signed [FENCE_W-1:0] lower;
  } swiqr_res_t;

endpackage

// File: sv/sliding_window_iqr_outlier_flag.sv
// Sliding-window Tukey IQR outlier test, one window of WINDOW samples per channel. A beat on
// an in-range channel is worked through in steps: the accept cycle swaps the sample into the
// channel's ring, ST_OLD fetches the removed sample, ST_SCAN walks the channel's sorted copy
// through its single read port counting ranks of the removed and the new sample, ST_MERGE
// rewrites the copy in order while picking off q1 (rank WINDOW/4) and q3 (rank 3*WINDOW/4),
// and ST_DONE loads the result register. A beat on a channel at or above CHANNELS gives an
// all-zero result and touches no state. The fences and outlier flag are held in an output
// register, so a finished result may wait while the next sample is already being worked on;
// the load of a new result waits, with in_stall high, while the previous one is still
// stalled there. in_stall is high while a sample is in progress. No clearing pass after
// reset: unwritten storage reads as zero through valid bits.
module sliding_window_iqr_outlier_flag import swiqr_pkg::*; #(
  parameter int WINDOW      = 16,
  parameter int CHANNELS    = 3,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CHAN_W-1:0]         channel,
  input  logic [SAMPLE_W-1:0]       sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      outlier,
  output logic [FENCE_W-1:0]        upper_fence,
  output logic signed [FENCE_W-1:0] lower_fence
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [SAMPLE_W-1:0] SMASK =
    (SAMPLE_BITS >= SAMPLE_W) ? '1 : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  swiqr_state_t state, state_next;

  logic [CNT_W-1:0]    cnt;
  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] samp_r;
  logic [SAMPLE_W-1:0] old_r;
  logic                bad_r;
  logic [CNT_W-1:0]    lt_old;
  logic [CNT_W-1:0]    lt_new;
  logic [CNT_W-1:0]    q_r;
  logic [SAMPLE_W-1:0] prev1;
  logic [SAMPLE_W-1:0] prev2;
  logic [SAMPLE_W-1:0] q1_r;
  logic [SAMPLE_W-1:0] q3_r;

  logic                in_acc;
  logic                in_range;
  logic [SAMPLE_W-1:0] samp_in;
  logic [CH_W-1:0]     ch_sel;
  logic                ring_go;
  logic [SAMPLE_W-1:0] ring_old;
  srt_ctl_t            srt_ctl;
  logic [POS_W-1:0]    srt_rd_idx;
  logic [POS_W-1:0]    srt_wr_idx;
  logic [SAMPLE_W-1:0] srt_rd;
  logic [SAMPLE_W-1:0] merge_val;
  logic [CNT_W-1:0]    j_idx;
  logic                inc_old;
  logic                inc_new;
  logic                out_load;
  swiqr_res_t          res;

  assign in_range = (32'(channel) < 32'(CHANNELS));
  assign samp_in  = sample & SMASK;
  assign in_acc   = in_valid && !in_stall;
  assign ch_sel   = (state == ST_IDLE) ? CH_W'(channel) : ch_r;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // Compare unit: current sorted entry against removed and new sample
  assign inc_old = (srt_rd < old_r);
  assign inc_new = (srt_rd < samp_r);

  // Merge pick: entry j of the new order from A[j-1], A[j], A[j+1]
  assign j_idx = cnt - CNT_W'(1);
  always_comb begin
    if (j_idx < q_r) begin
      merge_val = (j_idx < lt_old) ? prev1 : srt_rd;
    end else if (j_idx == q_r) begin
      merge_val = samp_r;
    end else begin
      merge_val = (j_idx <= lt_old) ? prev2 : prev1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = in_range ? ST_OLD : ST_DONE;
        end
      end
      ST_OLD: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(WINDOW - 1)) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (cnt == CNT_W'(WINDOW)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall    = 1'b1;
    ring_go     = 1'b0;
    srt_ctl     = '0;
    srt_rd_idx  = '0;
    srt_wr_idx  = j_idx[POS_W-1:0];
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ring_go  = in_valid && in_range;
      end
      ST_OLD: begin
        srt_ctl.rd_en = 1'b1;
      end
      ST_SCAN: begin
        srt_ctl.rd_en = 1'b1;
        srt_rd_idx    = (cnt == CNT_W'(WINDOW - 1)) ? '0 : POS_W'(cnt + CNT_W'(1));
      end
      ST_MERGE: begin
        srt_ctl.rd_en     = (cnt < CNT_W'(WINDOW - 1));
        srt_rd_idx        = POS_W'(cnt + CNT_W'(1));
        srt_ctl.wr_en     = (cnt != '0);
        srt_ctl.set_valid = (cnt == CNT_W'(WINDOW));
      end
      ST_DONE: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_OLD:   cnt <= '0;
        ST_SCAN:  cnt <= (cnt == CNT_W'(WINDOW - 1)) ? '0 : cnt + CNT_W'(1);
        ST_MERGE: cnt <= cnt + CNT_W'(1);
        default:  cnt <= '0;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          ch_r   <= CH_W'(channel);
          samp_r <= samp_in;
          bad_r  <= !in_range;
        end
      end
      ST_OLD: begin
        old_r  <= ring_old;
        lt_old <= '0;
        lt_new <= '0;
      end
      ST_SCAN: begin
        lt_old <= lt_old + CNT_W'(inc_old);
        lt_new <= lt_new + CNT_W'(inc_new);
        if (cnt == CNT_W'(WINDOW - 1)) begin
          q_r <= lt_new + CNT_W'(inc_new) - CNT_W'(old_r < samp_r);
        end
      end
      ST_MERGE: begin
        prev2 <= prev1;
        prev1 <= srt_rd;
        if (cnt == CNT_W'(WINDOW / 4 + 1)) begin
          q1_r <= merge_val;
        end
        if (cnt == CNT_W'((3 * WINDOW) / 4 + 1)) begin
          q3_r <= merge_val;
        end
      end
      default: begin
        prev2 <= prev2;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      outlier     <= res.outlier;
      upper_fence <= res.upper;
      lower_fence <= res.lower;
    end
  end

  swiqr_ring #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .go       (ring_go),
    .ch       (ch_sel),
    .wr_data  (samp_in),
    .old_data (ring_old)
  );

  swiqr_sorted #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_sorted (
    .clk     (clk),
    .rst     (rst),
    .ctl     (srt_ctl),
    .ch      (ch_r),
    .rd_idx  (srt_rd_idx),
    .wr_idx  (srt_wr_idx),
    .wr_data (merge_val),
    .rd_data (srt_rd)
  );

  swiqr_fence u_fence (
    .q1     (q1_r),
    .q3     (q3_r),
    .sample (samp_r),
    .zero   (bad_r),
    .res    (res)
  );

endmodule

// File: sv/swiqr_ring.sv
// Per-channel sample ring with write positions; swaps in the new sample and returns the oldest.
module swiqr_ring import swiqr_pkg::*; #(
  parameter int WINDOW   = 16,
  parameter int CHANNELS = 3
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        go,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ch,
  input  logic [SAMPLE_W-1:0]                         wr_data,
  output logic [SAMPLE_W-1:0]                         old_data
);

  localparam int POS_W  = $clog2(WINDOW);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid;
  logic [POS_W-1:0]    wpos [CHANNELS];
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_valid;
  logic [ADDR_W-1:0]   addr;
  logic [POS_W-1:0]    pos_cur;
  logic [POS_W-1:0]    pos_next;

  // Address of the oldest entry of the channel
  always_comb begin
    pos_cur  = wpos[ch];
    addr     = ADDR_W'(ch) * ADDR_W'(WINDOW) + ADDR_W'(pos_cur);
    pos_next = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + POS_W'(1);
  end

  // Storage: read old value, write new one at the same entry
  always_ff @(posedge clk) begin
    if (go) begin
      rd_data   <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

  // Entry valid bits and write positions
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wpos[i] <= '0;
      end
    end else if (go) begin
      rd_valid    <= valid[addr];
      valid[addr] <= 1'b1;
      wpos[ch]    <= pos_next;
    end
  end

  // Never-written entries read as zero
  assign old_data = rd_valid ? rd_data : '0;

endmodule

// File: sv/swiqr_sorted.sv
// Per-channel ascending copy of the window, one read and one write port.
module swiqr_sorted import swiqr_pkg::*; #(
  parameter int WINDOW   = 16,
  parameter int CHANNELS = 3
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  srt_ctl_t                                    ctl,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] ch,
  input  logic [$clog2(WINDOW)-1:0]                   rd_idx,
  input  logic [$clog2(WINDOW)-1:0]                   wr_idx,
  input  logic [SAMPLE_W-1:0]                         wr_data,
  output logic [SAMPLE_W-1:0]                         rd_data
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [CHANNELS-1:0] ch_valid;
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_valid;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   waddr;

  assign base  = ADDR_W'(ch) * ADDR_W'(WINDOW);
  assign raddr = base + ADDR_W'(rd_idx);
  assign waddr = base + ADDR_W'(wr_idx);

  // Storage
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q <= mem[raddr];
    end
    if (ctl.wr_en) begin
      mem[waddr] <= wr_data;
    end
  end

  // A channel's copy is valid once its first full rewrite is done
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rd_valid <= ch_valid[ch];
      end
      if (ctl.set_valid) begin
        ch_valid[ch] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// File: sv/swiqr_fence.sv
// Tukey fence arithmetic from the quartiles, plus the outlier compare.
module swiqr_fence import swiqr_pkg::*; (
  input  logic [SAMPLE_W-1:0] q1,
  input  logic [SAMPLE_W-1:0] q3,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                zero,
  output swiqr_res_t          res
);

  logic [SAMPLE_W-1:0] iqr;
  logic [SAMPLE_W:0]   spread;
  logic [FENCE_W-1:0]  upper;
  logic [FENCE_W-1:0]  lower;

  always_comb begin
    // q3 >= q1 always, so the difference fits
    iqr    = q3 - q1;
    spread = {1'b0, iqr} + {2'b00, iqr[SAMPLE_W-1:1]};
    upper  = {2'b00, q3} + {1'b0, spread};
    lower  = {2'b00, q1} - {1'b0, spread};
    if (zero) begin
      res = '0;
    end else begin
      res.outlier = ({2'b00, sample} > upper);
      res.upper   = upper;
      res.lower   = signed'(lower);
    end
  end

endmodule
